// ===== hdl/cwpc_pkg.sv =====
// shared types and constants of the chroma window pixel classifier
// no dependencies; read first by every other file of the block but cwpc_hit_if
`default_nettype none

package cwpc_pkg;

  localparam int PIX_W   = 8;
  localparam int GAIN_W  = 16;
  localparam int BOUND_W = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // fixed-point conversion to Cr
  localparam int YC_SHIFT = 14;
  localparam int Y_SUM_W  = 22;
  localparam logic [13:0] Y_COEF_R = 14'd4899;
  localparam logic [13:0] Y_COEF_G = 14'd9617;
  localparam logic [13:0] Y_COEF_B = 14'd1868;
  localparam logic [Y_SUM_W-1:0] Y_ROUND = 22'd8192;

  localparam int CR_T_W = 24;
  localparam logic signed [14:0] CR_COEF = 15'sd11682;
  localparam logic signed [CR_T_W-1:0] CR_BIAS = 24'sd2105344;
  localparam int CR_Q_W = CR_T_W - YC_SHIFT;
  localparam logic signed [CR_Q_W-1:0] PIX_MAX = 10'sd255;

  // window test; gains and score in 1/4096 units, window bounds in 1/16 units
  localparam int SCORE_W = 26;
  localparam logic signed [8:0] CHROMA_PIVOT = 9'sd125;
  localparam logic signed [SCORE_W-1:0] PIVOT_SCALED = 26'sd512000;

  localparam logic [GAIN_W-1:0]  RED_GAIN_RST   = 16'd4096;
  localparam logic [GAIN_W-1:0]  GREEN_GAIN_RST = 16'd4096;
  localparam logic [BOUND_W-1:0] RED_LO_RST     = 18'd2320;
  localparam logic [BOUND_W-1:0] RED_HI_RST     = 18'd7520;
  localparam logic [BOUND_W-1:0] GREEN_LO_RST   = 18'd1520;
  localparam logic [BOUND_W-1:0] GREEN_HI_RST   = 18'd1760;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED_GAIN   = 3'd0,
    REG_GREEN_GAIN = 3'd1,
    REG_RED_LO     = 3'd2,
    REG_RED_HI     = 3'd3,
    REG_GREEN_LO   = 3'd4,
    REG_GREEN_HI   = 3'd5
  } cwpc_reg_idx_t;

  // load enables of the two window stages
  typedef struct packed {
    logic load_score;
    logic load_hit;
  } cwpc_stage_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/cwpc_pix_if.sv =====
// valid/ready channel carrying one bgr pixel
// depends on cwpc_pkg
`default_nettype none

interface cwpc_pix_if;
  import cwpc_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] blue_value;
  logic [PIX_W-1:0] green_value;
  logic [PIX_W-1:0] red_value;

  modport source (output valid, blue_value, green_value, red_value, input ready);
  modport sink   (input valid, blue_value, green_value, red_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/cwpc_hit_if.sv =====
// valid/ready channel carrying the red and green mask bits
// no dependencies
`default_nettype none

interface cwpc_hit_if;
  logic valid;
  logic ready;
  logic red_hit;
  logic green_hit;

  modport source (output valid, red_hit, green_hit, input ready);
  modport sink   (input valid, red_hit, green_hit, output ready);
endinterface

`default_nettype wire

// ===== hdl/cwpc_window.sv =====
// gain scaling of cr and exclusive window test for one color, two register stages
// depends on cwpc_pkg
`default_nettype none

module cwpc_window (
  input  wire logic                              clk,
  input  wire cwpc_pkg::cwpc_stage_ctl_t         ctl,
  input  wire logic [cwpc_pkg::PIX_W-1:0]        cr,
  input  wire logic [cwpc_pkg::GAIN_W-1:0]       gain,
  input  wire logic [cwpc_pkg::BOUND_W-1:0]      low_bound,
  input  wire logic [cwpc_pkg::BOUND_W-1:0]      high_bound,
  output logic                                   hit
);
  import cwpc_pkg::*;

  logic signed [8:0]         cr_diff;
  logic signed [GAIN_W:0]    gain_s;
  logic signed [SCORE_W-1:0] score_nxt;
  logic signed [SCORE_W-1:0] score_r;
  logic signed [SCORE_W-1:0] low_scaled;
  logic signed [SCORE_W-1:0] high_scaled;
  logic                      hit_nxt;
  logic                      hit_r;

  assign cr_diff   = $signed({1'b0, cr}) - CHROMA_PIVOT;
  assign gain_s    = $signed({1'b0, gain});
  assign score_nxt = SCORE_W'(cr_diff) * SCORE_W'(gain_s) + PIVOT_SCALED;

  assign low_scaled  = $signed({low_bound, 8'd0});
  assign high_scaled = $signed({high_bound, 8'd0});
  assign hit_nxt     = (score_r > low_scaled) && (score_r < high_scaled);

  always_ff @(posedge clk) begin
    if (ctl.load_score) begin
      score_r <= score_nxt;
    end
    if (ctl.load_hit) begin
      hit_r <= hit_nxt;
    end
  end

  assign hit = hit_r;

endmodule

`default_nettype wire

// ===== hdl/chroma_window_pixel_classifier.sv =====
// Chroma window pixel classifier, top level.
// Depends on cwpc_pkg, cwpc_pix_if, cwpc_hit_if and cwpc_window.
//
// Usage:
//   in_px   valid/ready channel, one bgr pixel per transaction
//   out_hit valid/ready channel, red_hit and green_hit per transaction
//   cfg_*   write port for gains and window bounds, written while idle
// Each pixel gives exactly one result. The datapath is a four-stage
// pipeline: luma, cr with saturation, gain multiply, window compare.
// out_hit.valid rises once the pixel has passed the luma, cr, score and
// hit registers in that order; a low out_hit.ready can hold it on the way.
// Throughput is one pixel per cycle while out_hit.ready stays high; the
// multipliers of the gain stage and the luma sum set the stage depth.
// Reset clears all valid bits and loads the default gains (1.0) and
// window bounds; no result is pending afterwards.
// When the receiver holds out_hit.ready low, the result stays in the
// output register and earlier stages keep filling their empty slots;
// in_px.ready drops only once every stage holds a pixel.
`default_nettype none

module chroma_window_pixel_classifier (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  cwpc_pix_if.sink                             in_px,
  cwpc_hit_if.source                           out_hit,
  input  wire logic                            cfg_we,
  input  wire logic [cwpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cwpc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cwpc_pkg::*;

  logic [GAIN_W-1:0]  red_gain_r;
  logic [GAIN_W-1:0]  green_gain_r;
  logic [BOUND_W-1:0] red_lo_r;
  logic [BOUND_W-1:0] red_hi_r;
  logic [BOUND_W-1:0] green_lo_r;
  logic [BOUND_W-1:0] green_hi_r;

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  logic [Y_SUM_W-1:0]       y_sum;
  logic [PIX_W-1:0]         y_r;
  logic [PIX_W-1:0]         red1_r;
  logic signed [PIX_W:0]    rmy;
  logic signed [CR_T_W-1:0] cr_t;
  logic signed [CR_Q_W-1:0] cr_q;
  logic [PIX_W-1:0]         cr_nxt;
  logic [PIX_W-1:0]         cr_r;

  cwpc_stage_ctl_t win_ctl;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_gain_r   <= RED_GAIN_RST;
      green_gain_r <= GREEN_GAIN_RST;
      red_lo_r     <= RED_LO_RST;
      red_hi_r     <= RED_HI_RST;
      green_lo_r   <= GREEN_LO_RST;
      green_hi_r   <= GREEN_HI_RST;
    end else if (cfg_we) begin
      unique case (cwpc_reg_idx_t'(cfg_index))
        REG_RED_GAIN:   red_gain_r   <= cfg_data[GAIN_W-1:0];
        REG_GREEN_GAIN: green_gain_r <= cfg_data[GAIN_W-1:0];
        REG_RED_LO:     red_lo_r     <= cfg_data[BOUND_W-1:0];
        REG_RED_HI:     red_hi_r     <= cfg_data[BOUND_W-1:0];
        REG_GREEN_LO:   green_lo_r   <= cfg_data[BOUND_W-1:0];
        REG_GREEN_HI:   green_hi_r   <= cfg_data[BOUND_W-1:0];
        default: ;
      endcase
    end
  end

  // stage enables, a stage loads when empty or when it drains
  assign en4 = !v4_r || out_hit.ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_px.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_px.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // stage 1: luma
  assign y_sum = Y_COEF_R * Y_SUM_W'(in_px.red_value)
               + Y_COEF_G * Y_SUM_W'(in_px.green_value)
               + Y_COEF_B * Y_SUM_W'(in_px.blue_value)
               + Y_ROUND;

  // stage 2: cr with rounding and saturation
  assign rmy    = $signed({1'b0, red1_r}) - $signed({1'b0, y_r});
  assign cr_t   = CR_T_W'(rmy) * CR_T_W'(CR_COEF) + CR_BIAS;
  assign cr_q   = CR_Q_W'(cr_t >>> YC_SHIFT);

  always_comb begin
    priority if (cr_q < 0) begin
      cr_nxt = '0;
    end else if (cr_q > PIX_MAX) begin
      cr_nxt = '1;
    end else begin
      cr_nxt = cr_q[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      y_r    <= y_sum[Y_SUM_W-1:YC_SHIFT];
      red1_r <= in_px.red_value;
    end
    if (en2) begin
      cr_r <= cr_nxt;
    end
  end

  // stages 3 and 4: scaling and window compare per color
  assign win_ctl = '{load_score: en3, load_hit: en4};

  cwpc_window u_red_win (
    .clk        (clk),
    .ctl        (win_ctl),
    .cr         (cr_r),
    .gain       (red_gain_r),
    .low_bound  (red_lo_r),
    .high_bound (red_hi_r),
    .hit        (out_hit.red_hit)
  );

  cwpc_window u_green_win (
    .clk        (clk),
    .ctl        (win_ctl),
    .cr         (cr_r),
    .gain       (green_gain_r),
    .low_bound  (green_lo_r),
    .high_bound (green_hi_r),
    .hit        (out_hit.green_hit)
  );

  assign out_hit.valid = v4_r;

endmodule

`default_nettype wire
